// ----- sv/prsc_pkg.sv -----
package prsc_pkg;

    localparam int NUM_STAGES = 8;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 136;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_EMPTY       = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [2:0] REG_ROW_ALIGNMENT   = 3'd0;
    localparam logic [2:0] REG_ROW_LENGTH      = 3'd1;
    localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_SKIP_PIXELS     = 3'd3;
    localparam logic [2:0] REG_SKIP_ROWS       = 3'd4;
    localparam logic [2:0] REG_SKIP_IMAGES     = 3'd5;

    typedef struct packed {
        logic [5:0] bpg;
        status_t    status;
    } decode_t;

    // floor(2^32 / a); alignment one uses all ones and relies on the
    // single correction step after the quotient estimate.
    function automatic logic [31:0] align_recip(input logic [3:0] a);
        logic [31:0] m;
        case (a)
            4'd2:    m = 32'h8000_0000;
            4'd3:    m = 32'h5555_5555;
            4'd4:    m = 32'h4000_0000;
            4'd5:    m = 32'h3333_3333;
            4'd6:    m = 32'h2AAA_AAAA;
            4'd7:    m = 32'h2492_4924;
            4'd8:    m = 32'h2000_0000;
            4'd9:    m = 32'h1C71_C71C;
            4'd10:   m = 32'h1999_9999;
            4'd11:   m = 32'h1745_D174;
            4'd12:   m = 32'h1555_5555;
            4'd13:   m = 32'h13B1_3B13;
            4'd14:   m = 32'h1249_2492;
            4'd15:   m = 32'h1111_1111;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/prsc_decode.sv -----
module prsc_decode (
    input  logic [4:0]        format_code,
    input  logic [4:0]        type_code,
    input  logic [30:0]       region_width,
    input  logic [30:0]       region_height,
    input  logic [30:0]       region_depth,
    output prsc_pkg::decode_t dec
);

    logic [2:0] comp;
    logic [5:0] bpg;

    always_comb
    begin
        case (format_code) inside
            [5'd0:5'd5]:   comp = 3'd1;
            [5'd6:5'd8]:   comp = 3'd2;
            [5'd9:5'd11]:  comp = 3'd3;
            [5'd12:5'd15]: comp = 3'd4;
            default:       comp = 3'd0;
        endcase
    end

    always_comb
    begin
        if (comp == 3'd0)
        begin
            bpg = 6'd0;
        end
        else
        begin
            case (type_code) inside
                [5'd0:5'd2]:   bpg = 6'd2;
                [5'd3:5'd6]:   bpg = 6'd4;
                [5'd7:5'd8]:   bpg = {3'b000, comp};
                [5'd9:5'd12]:  bpg = {2'b00, comp, 1'b0};
                [5'd13:5'd15]: bpg = {1'b0, comp, 2'b00};
                5'd16:         bpg = {comp, 3'b000};
                default:       bpg = 6'd0;
            endcase
        end
    end

    always_comb
    begin
        dec.bpg = bpg;
        if (bpg == 6'd0)
        begin
            dec.status = prsc_pkg::ST_UNSUPPORTED;
        end
        else if (region_width == '0 || region_height == '0 || region_depth == '0)
        begin
            dec.status = prsc_pkg::ST_EMPTY;
        end
        else
        begin
            dec.status = prsc_pkg::ST_OK;
        end
    end

endmodule

// ----- sv/pixel_rectangle_size_calc_core.sv -----
// Throughput: one transaction per cycle while m_tready holds high; an eight-stage
// pipeline with per-stage valid bits, the 32x32 multiply stages setting the clock.
// Reset: rst_n is asynchronous, active low; it empties the pipeline and loads
// the configuration registers with alignment 4 and zero overrides and skips.
module pixel_rectangle_size_calc_core (
    input  logic         clk,
    input  logic         rst_n,

    // Configuration write port
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_wdata,

    // Request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // format_code[4:0], type_code[9:5], region_width[40:10],
    // region_height[71:41], region_depth[102:72], zero pad [103]
    input  logic [prsc_pkg::IN_DATA_W-1:0] s_tdata,

    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], initial_skip_bytes[33:2], image_bytes[65:34],
    // aligned_row_bytes[97:66], last_row_bytes[129:98], zero pad [135:130]
    output logic [prsc_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int NS = prsc_pkg::NUM_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]  row_alignment_reg;
    logic [30:0] row_length_override_reg;
    logic [30:0] image_height_override_reg;
    logic [30:0] skip_pixel_count_reg;
    logic [30:0] skip_row_count_reg;
    logic [30:0] skip_image_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_alignment_reg         <= 4'd4;
            row_length_override_reg   <= '0;
            image_height_override_reg <= '0;
            skip_pixel_count_reg      <= '0;
            skip_row_count_reg        <= '0;
            skip_image_count_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                prsc_pkg::REG_ROW_ALIGNMENT: row_alignment_reg         <= cfg_wdata[3:0];
                prsc_pkg::REG_ROW_LENGTH:    row_length_override_reg   <= cfg_wdata;
                prsc_pkg::REG_IMAGE_HEIGHT:  image_height_override_reg <= cfg_wdata;
                prsc_pkg::REG_SKIP_PIXELS:   skip_pixel_count_reg      <= cfg_wdata;
                prsc_pkg::REG_SKIP_ROWS:     skip_row_count_reg        <= cfg_wdata;
                prsc_pkg::REG_SKIP_IMAGES:   skip_image_count_reg      <= cfg_wdata;
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage advances when it is empty or the stage
    // after it advances. Bubbles collapse, so a waiting result at the
    // output does not block the stages behind it while they hold space.
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] adv;

    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NS-1];

    // ------------------------------------------------------------------
    // Stage 1: unpack the transaction, decode bytes per group and the
    // early status, resolve the zero-means-default registers.
    // ------------------------------------------------------------------
    logic [4:0]  in_format;
    logic [4:0]  in_type;
    logic [30:0] in_width;
    logic [30:0] in_height;
    logic [30:0] in_depth;
    prsc_pkg::decode_t dec;

    assign in_format = s_tdata[4:0];
    assign in_type   = s_tdata[9:5];
    assign in_width  = s_tdata[40:10];
    assign in_height = s_tdata[71:41];
    assign in_depth  = s_tdata[102:72];

    prsc_decode u_decode (
        .format_code   (in_format),
        .type_code     (in_type),
        .region_width  (in_width),
        .region_height (in_height),
        .region_depth  (in_depth),
        .dec           (dec)
    );

    logic [5:0]        s1_bpg_reg;
    prsc_pkg::status_t s1_status_reg;
    logic [3:0]        s1_align_reg;
    logic [30:0]       s1_rowlen_reg;
    logic [30:0]       s1_imgh_reg;
    logic [30:0]       s1_w_reg;
    logic [30:0]       s1_h_reg;
    logic [30:0]       s1_dm1_reg;

    logic [3:0]  s1_align_next;
    logic [30:0] s1_rowlen_next;
    logic [30:0] s1_imgh_next;

    assign s1_align_next  = (row_alignment_reg == 4'd0) ? 4'd1 : row_alignment_reg;
    assign s1_rowlen_next = (row_length_override_reg != '0) ? row_length_override_reg
                                                            : in_width;
    assign s1_imgh_next   = (image_height_override_reg != '0) ? image_height_override_reg
                                                              : in_height;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_bpg_reg    <= dec.bpg;
            s1_status_reg <= dec.status;
            s1_align_reg  <= s1_align_next;
            s1_rowlen_reg <= s1_rowlen_next;
            s1_imgh_reg   <= s1_imgh_next;
            s1_w_reg      <= in_width;
            s1_h_reg      <= in_height;
            s1_dm1_reg    <= in_depth - 31'd1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first products. Row bytes, last row bytes, skip pixel
    // bytes, slice rows and skipped slice rows. Any bit above 32 flags
    // overflow; only the low word travels on.
    // ------------------------------------------------------------------
    logic [36:0] padded_p;
    logic [36:0] last_p;
    logic [36:0] spx_p;
    logic [61:0] t1_p;
    logic [61:0] t2_p;
    logic        s2_ovf_next;

    assign padded_p = 37'(s1_rowlen_reg) * 37'(s1_bpg_reg);
    assign last_p   = 37'(s1_w_reg) * 37'(s1_bpg_reg);
    assign spx_p    = 37'(skip_pixel_count_reg) * 37'(s1_bpg_reg);
    assign t1_p     = 62'(s1_imgh_reg) * 62'(s1_dm1_reg);
    assign t2_p     = 62'(s1_imgh_reg) * 62'(skip_image_count_reg);

    assign s2_ovf_next = (|padded_p[36:32]) | (|last_p[36:32]) | (|spx_p[36:32])
                       | (|t1_p[61:32]) | (|t2_p[61:32]);

    prsc_pkg::status_t s2_status_reg;
    logic              s2_ovf_reg;
    logic [3:0]        s2_align_reg;
    logic [30:0]       s2_h_reg;
    logic [31:0]       s2_padded_reg;
    logic [31:0]       s2_last_reg;
    logic [31:0]       s2_spx_reg;
    logic [31:0]       s2_t1_reg;
    logic [31:0]       s2_t2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_status_reg <= s1_status_reg;
            s2_ovf_reg    <= s2_ovf_next;
            s2_align_reg  <= s1_align_reg;
            s2_h_reg      <= s1_h_reg;
            s2_padded_reg <= padded_p[31:0];
            s2_last_reg   <= last_p[31:0];
            s2_spx_reg    <= spx_p[31:0];
            s2_t1_reg     <= t1_p[31:0];
            s2_t2_reg     <= t2_p[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient estimate of row bytes by the alignment through
    // the reciprocal table; total rows and skipped rows.
    // ------------------------------------------------------------------
    logic [63:0] quo_p;
    logic [32:0] rows_s;
    logic [32:0] t3_s;
    logic        s3_ovf_next;

    assign quo_p  = 64'(s2_padded_reg) * 64'(prsc_pkg::align_recip(s2_align_reg));
    assign rows_s = 33'(s2_t1_reg) + 33'(s2_h_reg);
    assign t3_s   = 33'(s2_t2_reg) + 33'(skip_row_count_reg);
    assign s3_ovf_next = s2_ovf_reg | rows_s[32] | t3_s[32];

    prsc_pkg::status_t s3_status_reg;
    logic              s3_ovf_reg;
    logic [3:0]        s3_align_reg;
    logic [31:0]       s3_quo_reg;
    logic [31:0]       s3_padded_reg;
    logic [31:0]       s3_last_reg;
    logic [31:0]       s3_spx_reg;
    logic [31:0]       s3_rows_reg;
    logic [31:0]       s3_t3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_status_reg <= s2_status_reg;
            s3_ovf_reg    <= s3_ovf_next;
            s3_align_reg  <= s2_align_reg;
            s3_quo_reg    <= quo_p[63:32];
            s3_padded_reg <= s2_padded_reg;
            s3_last_reg   <= s2_last_reg;
            s3_spx_reg    <= s2_spx_reg;
            s3_rows_reg   <= rows_s[31:0];
            s3_t3_reg     <= t3_s[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: raw remainder. The estimate is the true quotient or one
    // below it, so the difference stays under twice the alignment.
    // ------------------------------------------------------------------
    logic [35:0] qa_p;
    logic [31:0] rem_diff;

    assign qa_p     = 36'(s3_quo_reg) * 36'(s3_align_reg);
    assign rem_diff = s3_padded_reg - qa_p[31:0];

    prsc_pkg::status_t s4_status_reg;
    logic              s4_ovf_reg;
    logic [3:0]        s4_align_reg;
    logic [4:0]        s4_rem_reg;
    logic [31:0]       s4_padded_reg;
    logic [31:0]       s4_last_reg;
    logic [31:0]       s4_spx_reg;
    logic [31:0]       s4_rows_m1_reg;
    logic [31:0]       s4_t3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_status_reg  <= s3_status_reg;
            s4_ovf_reg     <= s3_ovf_reg;
            s4_align_reg   <= s3_align_reg;
            s4_rem_reg     <= rem_diff[4:0];
            s4_padded_reg  <= s3_padded_reg;
            s4_last_reg    <= s3_last_reg;
            s4_spx_reg     <= s3_spx_reg;
            s4_rows_m1_reg <= s3_rows_reg - 32'd1;
            s4_t3_reg      <= s3_t3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: correct the remainder and round the row up to alignment.
    // ------------------------------------------------------------------
    logic [4:0]  rem_c;
    logic [4:0]  pad_add;
    logic [32:0] aligned_s;
    logic        s5_ovf_next;

    assign rem_c     = (s4_rem_reg >= 5'(s4_align_reg)) ? s4_rem_reg - 5'(s4_align_reg)
                                                        : s4_rem_reg;
    assign pad_add   = 5'(s4_align_reg) - rem_c;
    assign aligned_s = (rem_c != 5'd0) ? 33'(s4_padded_reg) + 33'(pad_add)
                                       : 33'(s4_padded_reg);
    assign s5_ovf_next = s4_ovf_reg | aligned_s[32];

    prsc_pkg::status_t s5_status_reg;
    logic              s5_ovf_reg;
    logic [31:0]       s5_aligned_reg;
    logic [31:0]       s5_last_reg;
    logic [31:0]       s5_spx_reg;
    logic [31:0]       s5_rows_m1_reg;
    logic [31:0]       s5_t3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_status_reg  <= s4_status_reg;
            s5_ovf_reg     <= s5_ovf_next;
            s5_aligned_reg <= aligned_s[31:0];
            s5_last_reg    <= s4_last_reg;
            s5_spx_reg     <= s4_spx_reg;
            s5_rows_m1_reg <= s4_rows_m1_reg;
            s5_t3_reg      <= s4_t3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: pitch times full rows, pitch times skipped rows.
    // ------------------------------------------------------------------
    logic [63:0] img_p;
    logic [63:0] skp_p;
    logic        s6_ovf_next;

    assign img_p = 64'(s5_aligned_reg) * 64'(s5_rows_m1_reg);
    assign skp_p = 64'(s5_aligned_reg) * 64'(s5_t3_reg);
    assign s6_ovf_next = s5_ovf_reg | (|img_p[63:32]) | (|skp_p[63:32]);

    prsc_pkg::status_t s6_status_reg;
    logic              s6_ovf_reg;
    logic [31:0]       s6_aligned_reg;
    logic [31:0]       s6_last_reg;
    logic [31:0]       s6_spx_reg;
    logic [31:0]       s6_img_reg;
    logic [31:0]       s6_skp_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_status_reg  <= s5_status_reg;
            s6_ovf_reg     <= s6_ovf_next;
            s6_aligned_reg <= s5_aligned_reg;
            s6_last_reg    <= s5_last_reg;
            s6_spx_reg     <= s5_spx_reg;
            s6_img_reg     <= img_p[31:0];
            s6_skp_reg     <= skp_p[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: add the last row to the image span, the skipped pixels
    // to the skip span.
    // ------------------------------------------------------------------
    logic [32:0] img_s;
    logic [32:0] skip_s;
    logic        s7_ovf_next;

    assign img_s  = 33'(s6_img_reg) + 33'(s6_last_reg);
    assign skip_s = 33'(s6_skp_reg) + 33'(s6_spx_reg);
    assign s7_ovf_next = s6_ovf_reg | img_s[32] | skip_s[32];

    prsc_pkg::status_t s7_status_reg;
    logic              s7_ovf_reg;
    logic [31:0]       s7_aligned_reg;
    logic [31:0]       s7_last_reg;
    logic [31:0]       s7_img_reg;
    logic [31:0]       s7_skip_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s7_status_reg  <= s6_status_reg;
            s7_ovf_reg     <= s7_ovf_next;
            s7_aligned_reg <= s6_aligned_reg;
            s7_last_reg    <= s6_last_reg;
            s7_img_reg     <= img_s[31:0];
            s7_skip_reg    <= skip_s[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8 (output register): the whole footprint must fit 32 bits
    // too. Unsupported and empty keep their status; otherwise an
    // overflow anywhere wins. Sizes go out only with an ok status.
    // ------------------------------------------------------------------
    logic [32:0]                      total_s;
    prsc_pkg::status_t                final_status;
    logic [prsc_pkg::OUT_DATA_W-1:0]  m_tdata_next;
    logic [prsc_pkg::OUT_DATA_W-1:0]  m_tdata_reg;

    assign total_s = 33'(s7_skip_reg) + 33'(s7_img_reg);

    always_comb
    begin
        final_status = s7_status_reg;
        if (s7_status_reg == prsc_pkg::ST_OK && (s7_ovf_reg || total_s[32]))
        begin
            final_status = prsc_pkg::ST_OVERFLOW;
        end
        m_tdata_next = '0;
        m_tdata_next[1:0] = final_status;
        if (final_status == prsc_pkg::ST_OK)
        begin
            m_tdata_next[33:2]   = s7_skip_reg;
            m_tdata_next[65:34]  = s7_img_reg;
            m_tdata_next[97:66]  = s7_aligned_reg;
            m_tdata_next[129:98] = s7_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // Hold off requests only when every stage is full and the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld_reg) && !m_tready)
    else $error("input stalled while the pipeline had room");

    // An accepted transaction lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[0])
    else $error("accepted transaction lost at pipeline entry");

    // Sizes leave only with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != prsc_pkg::ST_OK |-> m_tdata[135:2] == '0)
    else $error("nonzero sizes with a failing status");

    // A stalled final stage keeps its contents until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && !m_tready |=> vld_reg[NS-1] && $stable(m_tdata_reg))
    else $error("output register changed while stalled");
`endif

endmodule
